// File: rtl/ir_pulse_width_bit_decoder_core_assert.svh
// Assertion macros for the IR pulse-width bit decoder.
`ifndef IR_PULSE_WIDTH_BIT_DECODER_CORE_ASSERT_SVH
`define IR_PULSE_WIDTH_BIT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define IRPWD_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define IRPWD_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: rtl/irpwd_pkg.sv
// Package with the item types and constants of the IR pulse-width bit decoder.
`default_nettype none

package irpwd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_GAP_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH      = 3'd4;

    localparam logic [7:0] GAP_THRESHOLD_RST = 8'd200;
    localparam logic [7:0] ZERO_LOW_RST      = 8'd10;
    localparam logic [7:0] ZERO_HIGH_RST     = 8'd30;
    localparam logic [7:0] ONE_LOW_RST       = 8'd40;
    localparam logic [7:0] ONE_HIGH_RST      = 8'd60;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam logic OP_PULSE   = 1'b0;
    localparam logic OP_SILENCE = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pulse_width;
        logic [7:0] gap_width;
    } in_item_t;

    typedef struct packed {
        logic [15:0] frame_data;
        logic [7:0]  frame_length;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/ir_pulse_width_bit_decoder_core.sv
// Top level of the IR pulse-width bit decoder.
// Usage:
//   in channel (in_valid, in_stall, in_item): one event per item, either a
//   measured pulse (pulse width plus the gap before it) or a silence timeout.
//   out channel (out_valid, out_stall, out_item): one frame per silence item
//   taken outside error-wait mode, carrying the last sixteen bits and the
//   saturating bit count.
//   cfg port (cfg_wr_en, cfg_index, cfg_data): writes the gap threshold and
//   the zero and one window bounds; write only while the block is idle.
// Timing:
//   An item is decoded in the cycle it is accepted; its frame is registered in
//   the output register, or in the skid stage while the output is stalled. One
//   item per cycle is taken while in_stall is low.
// Reset:
//   Clears the accumulator, count and wait flag, loads the default bounds and
//   empties the output register and the skid stage.
// Stall:
//   A stalled frame holds in the output register; a second frame parks in the
//   skid stage, and only then is in_stall raised until the output moves.
`default_nettype none
`include "ir_pulse_width_bit_decoder_core_assert.svh"

module ir_pulse_width_bit_decoder_core
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire irpwd_pkg::in_item_t                    in_item,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output irpwd_pkg::out_item_t                        out_item,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [irpwd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [irpwd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [7:0]  gap_threshold_reg;
    logic [7:0]  zero_low_reg;
    logic [7:0]  zero_high_reg;
    logic [7:0]  one_low_reg;
    logic [7:0]  one_high_reg;

    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic        wait_reg;
    logic        wait_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    irpwd_pkg::out_item_t out_item_reg;
    irpwd_pkg::out_item_t out_item_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    irpwd_pkg::out_item_t skid_item_reg;
    irpwd_pkg::out_item_t skid_item_next;

    logic                 in_fire;
    logic                 is_pulse;
    logic                 gap_new;
    logic                 is_zero;
    logic                 is_one;
    logic [15:0]          acc_base;
    logic [7:0]           count_base;
    logic                 wait_base;
    logic                 result_fire;
    irpwd_pkg::out_item_t result;
    logic                 out_take;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign is_pulse  = (in_item.opcode == irpwd_pkg::OP_PULSE);
    assign gap_new   = (in_item.gap_width >= gap_threshold_reg);
    assign is_zero   = (in_item.pulse_width > zero_low_reg) &&
                       (in_item.pulse_width < zero_high_reg);
    assign is_one    = (in_item.pulse_width > one_low_reg) &&
                       (in_item.pulse_width < one_high_reg);

    assign acc_base   = gap_new ? 16'd0 : acc_reg;
    assign count_base = gap_new ? 8'd0 : count_reg;
    assign wait_base  = gap_new ? 1'b0 : wait_reg;

    assign result_fire         = in_fire && !is_pulse && !wait_reg;
    assign result.frame_data   = acc_reg;
    assign result.frame_length = count_reg;

    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        if (in_fire && is_pulse)
        begin
            acc_next   = acc_base;
            count_next = count_base;
            wait_next  = wait_base;
            if (!wait_base)
            begin
                if (is_zero || is_one)
                begin
                    acc_next   = {acc_base[14:0], !is_zero};
                    count_next = (count_base == irpwd_pkg::COUNT_MAX) ?
                                 count_base : count_base + 8'd1;
                end
                else
                begin
                    wait_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = result_fire;
                out_item_next  = result;
            end
        end
        else if (result_fire)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_threshold_reg <= irpwd_pkg::GAP_THRESHOLD_RST;
            zero_low_reg      <= irpwd_pkg::ZERO_LOW_RST;
            zero_high_reg     <= irpwd_pkg::ZERO_HIGH_RST;
            one_low_reg       <= irpwd_pkg::ONE_LOW_RST;
            one_high_reg      <= irpwd_pkg::ONE_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                irpwd_pkg::REG_GAP_THRESHOLD: gap_threshold_reg <= cfg_data;
                irpwd_pkg::REG_ZERO_LOW:      zero_low_reg      <= cfg_data;
                irpwd_pkg::REG_ZERO_HIGH:     zero_high_reg     <= cfg_data;
                irpwd_pkg::REG_ONE_LOW:       one_low_reg       <= cfg_data;
                irpwd_pkg::REG_ONE_HIGH:      one_high_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= 16'd0;
            count_reg      <= 8'd0;
            wait_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            count_reg      <= count_next;
            wait_reg       <= wait_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    `IRPWD_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid holds an item while the output register is empty")
    `IRPWD_ASSERT_NEXT(a_frame_lands, clk, rst_n, result_fire && !out_valid_reg, out_valid_reg && (out_item_reg.frame_data == $past(acc_reg)), "frame not loaded into the output register")
    `IRPWD_ASSERT_NEXT(a_wait_holds, clk, rst_n, wait_reg && in_fire && is_pulse && !gap_new, wait_reg && $stable(acc_reg) && $stable(count_reg), "state changed in wait mode without a new gap")

endmodule

`default_nettype wire
